[rtl/core/ir_frame_pulse_distance_sender_top_assert.svh]
// ----------------------------------------------------------------------------
// ir frame sender assertion macros
// shared assertion forms for the checker of the frame sender
// ----------------------------------------------------------------------------
`ifndef IR_FRAME_PULSE_DISTANCE_SENDER_TOP_ASSERT_SVH
`define IR_FRAME_PULSE_DISTANCE_SENDER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define IRFPS_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("ir frame sender: same-cycle check failed");

// next-cycle implication, disabled during reset
`define IRFPS_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("ir frame sender: next-cycle check failed");

`endif

[rtl/core/irfps_pkg.sv]
// ----------------------------------------------------------------------------
// irfps_pkg
// types and constants shared by the ir frame sender modules
// ----------------------------------------------------------------------------
package irfps_pkg;

   // item kinds carried on the request tuser
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // register indexes on the csr channel
   localparam logic [3:0] CSR_HDR_MARK   = 4'd0;
   localparam logic [3:0] CSR_HDR_SPACE  = 4'd1;
   localparam logic [3:0] CSR_BIT_MARK   = 4'd2;
   localparam logic [3:0] CSR_ONE_SPACE  = 4'd3;
   localparam logic [3:0] CSR_ZERO_SPACE = 4'd4;
   localparam logic [3:0] CSR_TRL_MARK   = 4'd5;
   localparam logic [3:0] CSR_TRL_SPACE  = 4'd6;
   localparam logic [3:0] CSR_REPEAT     = 4'd7;

   // carrier period: high ticks then low ticks
   localparam logic [4:0] CARRIER_HIGH   = 5'd9;
   localparam logic [4:0] CARRIER_PERIOD = 5'd25;

   localparam logic [7:0] BYTE_MASK = 8'hff;

   // check bytes: complement of bytes 5..7 lands in 11..13
   localparam int CHECK_SRC = 5;
   localparam int CHECK_DST = 11;
   localparam int CHECK_LEN = 3;

   typedef enum logic [6:0] {
      PH_IDLE      = 7'b000_0001,
      PH_HDR_MARK  = 7'b000_0010,
      PH_HDR_SPACE = 7'b000_0100,
      PH_BIT_MARK  = 7'b000_1000,
      PH_BIT_SPACE = 7'b001_0000,
      PH_TRL_MARK  = 7'b010_0000,
      PH_TRL_SPACE = 7'b100_0000
   } phase_type;

   typedef struct packed {
      logic [9:0]  header_mark_periods;
      logic [15:0] header_space_us;
      logic [9:0]  bit_mark_periods;
      logic [15:0] one_space_us;
      logic [15:0] zero_space_us;
      logic [9:0]  trailer_mark_periods;
      logic [15:0] trailer_space_us;
      logic [3:0]  repeat_count;
   } cfg_type;

   // frame store control from the sequencer
   typedef struct packed {
      logic load_en;
      logic start_en;
   } store_ctl_type;

   // result word, ir_level in the lowest bit
   typedef struct packed {
      logic accepted;
      logic frame_done;
      logic busy_res;
      logic ir_level;
   } result_type;

endpackage

[rtl/core/irfps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// irfps_cfg_regs
// timing and repeat registers written over the csr channel
// ----------------------------------------------------------------------------
module irfps_cfg_regs (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [3:0]        wr_index,
   input  logic [15:0]       wr_data,
   output irfps_pkg::cfg_type cfg
);
   import irfps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_HDR_MARK:   cfg_in.header_mark_periods  = wr_data[9:0];
            CSR_HDR_SPACE:  cfg_in.header_space_us      = wr_data;
            CSR_BIT_MARK:   cfg_in.bit_mark_periods     = wr_data[9:0];
            CSR_ONE_SPACE:  cfg_in.one_space_us         = wr_data;
            CSR_ZERO_SPACE: cfg_in.zero_space_us        = wr_data;
            CSR_TRL_MARK:   cfg_in.trailer_mark_periods = wr_data[9:0];
            CSR_TRL_SPACE:  cfg_in.trailer_space_us     = wr_data;
            CSR_REPEAT:     cfg_in.repeat_count         = wr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_mark_periods  <= 10'd131;
         cfg_ff.header_space_us      <= 16'd1750;
         cfg_ff.bit_mark_periods     <= 10'd18;
         cfg_ff.one_space_us         <= 16'd1300;
         cfg_ff.zero_space_us        <= 16'd420;
         cfg_ff.trailer_mark_periods <= 10'd17;
         cfg_ff.trailer_space_us     <= 16'd17100;
         cfg_ff.repeat_count         <= 4'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/irfps_frame_store.sv]
// ----------------------------------------------------------------------------
// irfps_frame_store
// frame byte registers with load, check-byte fill and one read port
// ----------------------------------------------------------------------------
module irfps_frame_store #(
   parameter  int FRAME_BYTES = 18,
   localparam int IDX_W       = $clog2(FRAME_BYTES)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  irfps_pkg::store_ctl_type ctl,
   input  logic [4:0]               wr_index,
   input  logic [7:0]               wr_value,
   input  logic [IDX_W-1:0]         rd_index,
   output logic [7:0]               rd_data
);
   import irfps_pkg::*;

   logic [7:0] store_ff [FRAME_BYTES];
   logic [7:0] store_in [FRAME_BYTES];

   always_comb begin
      store_in = store_ff;
      if (ctl.load_en) begin
         // out-of-range index is taken but writes nothing
         if ({1'b0, wr_index} < 6'(FRAME_BYTES)) begin
            store_in[wr_index[IDX_W-1:0]] = wr_value;
         end
      end else if (ctl.start_en) begin
         for (int i = 0; i < CHECK_LEN; i++) begin
            store_in[CHECK_DST + i] = BYTE_MASK ^ store_ff[CHECK_SRC + i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '{default: '0};
      end else begin
         store_ff <= store_in;
      end
   end

   always_comb begin
      if ({1'b0, rd_index} < (IDX_W+1)'(FRAME_BYTES)) begin
         rd_data = store_ff[rd_index];
      end else begin
         rd_data = '0;
      end
   end

endmodule

[rtl/core/irfps_sequencer.sv]
// ----------------------------------------------------------------------------
// irfps_sequencer
// phase machine and counters for marks, spaces, bits, bytes and passes
// ----------------------------------------------------------------------------
module irfps_sequencer #(
   parameter  int FRAME_BYTES = 18,
   localparam int IDX_W       = $clog2(FRAME_BYTES)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [1:0]                op,
   input  irfps_pkg::cfg_type        cfg,
   input  logic [7:0]                cur_byte,
   output logic [IDX_W-1:0]          byte_pos,
   output irfps_pkg::store_ctl_type  ctl,
   output irfps_pkg::result_type     result
);
   import irfps_pkg::*;

   phase_type        phase_ff,  phase_in;
   logic [IDX_W-1:0] byte_ff,   byte_in;
   logic [2:0]       bit_ff,    bit_in;
   logic [3:0]       pass_ff,   pass_in;
   logic [9:0]       period_ff, period_in;
   logic [4:0]       carrier_ff, carrier_in;
   logic [15:0]      space_ff,  space_in;
   logic             level_ff,  level_in;

   logic             busy;
   logic             done;
   logic             acc;
   logic [9:0]       mark_len;
   logic [15:0]      space_len;
   logic [15:0]      bit_space;
   logic [4:0]       carrier_next;
   logic [IDX_W:0]   byte_next;

   function automatic logic [15:0] at_least_one(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

   assign busy = (phase_ff != PH_IDLE);

   // limits of the running mark and space
   always_comb begin
      unique case (phase_ff)
         PH_HDR_MARK: mark_len = 10'(at_least_one({6'd0, cfg.header_mark_periods}));
         PH_BIT_MARK: mark_len = 10'(at_least_one({6'd0, cfg.bit_mark_periods}));
         default:     mark_len = 10'(at_least_one({6'd0, cfg.trailer_mark_periods}));
      endcase
      bit_space = cur_byte[bit_ff] ? cfg.one_space_us : cfg.zero_space_us;
      unique case (phase_ff)
         PH_HDR_SPACE: space_len = at_least_one(cfg.header_space_us);
         PH_BIT_SPACE: space_len = at_least_one(bit_space);
         default:      space_len = at_least_one(cfg.trailer_space_us);
      endcase
   end

   assign carrier_next = carrier_ff + 5'd1;
   assign byte_next    = {1'b0, byte_ff} + (IDX_W+1)'(1);

   always_comb begin
      phase_in   = phase_ff;
      byte_in    = byte_ff;
      bit_in     = bit_ff;
      pass_in    = pass_ff;
      period_in  = period_ff;
      carrier_in = carrier_ff;
      space_in   = space_ff;
      level_in   = level_ff;
      done       = 1'b0;
      acc        = 1'b0;
      ctl        = '0;
      if (step) begin
         unique case (op)
            OP_LOAD: begin
               if (!busy) begin
                  ctl.load_en = 1'b1;
                  acc         = 1'b1;
               end
            end
            OP_START: begin
               if (!busy) begin
                  ctl.start_en = 1'b1;
                  acc          = 1'b1;
                  phase_in     = PH_HDR_MARK;
                  byte_in      = '0;
                  bit_in       = '0;
                  pass_in      = '0;
                  period_in    = '0;
                  carrier_in   = '0;
                  space_in     = '0;
               end
            end
            OP_TICK: begin
               unique case (phase_ff)
                  PH_HDR_MARK, PH_BIT_MARK, PH_TRL_MARK: begin
                     level_in = (carrier_ff < CARRIER_HIGH);
                     if (carrier_next >= CARRIER_PERIOD) begin
                        carrier_in = '0;
                        if ({1'b0, period_ff} + 11'd1 >= {1'b0, mark_len}) begin
                           period_in = '0;
                           space_in  = '0;
                           unique case (phase_ff)
                              PH_HDR_MARK: phase_in = PH_HDR_SPACE;
                              PH_BIT_MARK: phase_in = PH_BIT_SPACE;
                              default:     phase_in = PH_TRL_SPACE;
                           endcase
                        end else begin
                           period_in = period_ff + 10'd1;
                        end
                     end else begin
                        carrier_in = carrier_next;
                     end
                  end
                  PH_HDR_SPACE, PH_BIT_SPACE, PH_TRL_SPACE: begin
                     level_in = 1'b0;
                     if ({1'b0, space_ff} + 17'd1 >= {1'b0, space_len}) begin
                        space_in = '0;
                        unique case (phase_ff)
                           PH_HDR_SPACE: phase_in = PH_BIT_MARK;
                           PH_BIT_SPACE: begin
                              if (bit_ff == 3'd7) begin
                                 bit_in = '0;
                                 // last byte sent: on to the trailer
                                 if (byte_next >= (IDX_W+1)'(FRAME_BYTES)) begin
                                    byte_in  = '0;
                                    phase_in = PH_TRL_MARK;
                                 end else begin
                                    byte_in  = byte_next[IDX_W-1:0];
                                    phase_in = PH_BIT_MARK;
                                 end
                              end else begin
                                 bit_in   = bit_ff + 3'd1;
                                 phase_in = PH_BIT_MARK;
                              end
                           end
                           default: begin
                              if ({1'b0, pass_ff} + 5'd1 >=
                                  5'(at_least_one({12'd0, cfg.repeat_count}))) begin
                                 pass_in  = '0;
                                 phase_in = PH_IDLE;
                                 done     = 1'b1;
                              end else begin
                                 pass_in  = pass_ff + 4'd1;
                                 phase_in = PH_HDR_MARK;
                              end
                           end
                        endcase
                     end else begin
                        space_in = space_ff + 16'd1;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     level_in = 1'b0;
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         byte_ff    <= '0;
         bit_ff     <= '0;
         pass_ff    <= '0;
         period_ff  <= '0;
         carrier_ff <= '0;
         space_ff   <= '0;
         level_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         byte_ff    <= byte_in;
         bit_ff     <= bit_in;
         pass_ff    <= pass_in;
         period_ff  <= period_in;
         carrier_ff <= carrier_in;
         space_ff   <= space_in;
         level_ff   <= level_in;
      end
   end

   assign byte_pos          = byte_ff;
   assign result.ir_level   = level_in;
   assign result.busy_res   = (phase_in != PH_IDLE);
   assign result.frame_done = done;
   assign result.accepted   = acc;

endmodule

[rtl/core/ir_frame_pulse_distance_sender_top.sv]
// ----------------------------------------------------------------------------
// ir_frame_pulse_distance_sender_top
// pulse-distance infrared frame sender with 40 khz carrier marks
// ----------------------------------------------------------------------------
// usage
//   req channel: one word per item; tuser holds the kind (load, start, tick),
//   tdata holds the byte index and byte value for a load.
//   rsp channel: one word per request word, in order, giving the line level,
//   busy flag, frame-done pulse and accepted flag after that item.
//   csr channel: index/data writes to the timing and repeat registers, always
//   ready; write only while no item is in flight.
//   path: a request word taken sits in the input register, the sequencer
//   steps on it and loads the response register, which offers the response;
//   a stalled response holds the sequencer step back.
//   throughput: one item per cycle while the response side does not stall,
//   with one phase and counter update in the sequencer per item.
//   stalls: while rsp_tready is low the response word holds; one further
//   request is taken into the input register, then req_tready drops.
//   reset: synchronous; registers return to their defaults, the frame store
//   clears to zero, the sequencer goes idle with the line low and both
//   pipeline registers empty.
// ----------------------------------------------------------------------------
module ir_frame_pulse_distance_sender_top #(
   parameter int FRAME_BYTES = 18
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // byte_index[4:0], byte_value[12:5], zero pad
   input  logic [1:0]  req_tuser,   // op[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // ir_level[0], busy_res[1], frame_done[2],
                                    // accepted[3], zero pad
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [15:0] csr_data
);
   import irfps_pkg::*;

   localparam int IDX_W = $clog2(FRAME_BYTES);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_op_ff;
   logic [4:0]  in_idx_ff;
   logic [7:0]  in_val_ff;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff;

   logic             step;
   logic             req_take;
   cfg_type          cfg;
   store_ctl_type    ctl;
   result_type       result;
   logic [IDX_W-1:0] byte_pos;
   logic [7:0]       cur_byte;

   // the sequencer steps when the input register holds an item and the response register can take its result
   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff  <= req_tuser;
         in_idx_ff <= req_tdata[4:0];
         in_val_ff <= req_tdata[12:5];
      end
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   irfps_cfg_regs u_cfg_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   irfps_frame_store #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_frame_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .wr_index (in_idx_ff),
      .wr_value (in_val_ff),
      .rd_index (byte_pos),
      .rd_data  (cur_byte)
   );

   irfps_sequencer #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .op       (in_op_ff),
      .cfg      (cfg),
      .cur_byte (cur_byte),
      .byte_pos (byte_pos),
      .ctl      (ctl),
      .result   (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

endmodule

[rtl/core/irfps_checker.sv]
// ----------------------------------------------------------------------------
// irfps_checker
// port-level checks on the response channel of the frame sender
// ----------------------------------------------------------------------------
`include "ir_frame_pulse_distance_sender_top_assert.svh"

module irfps_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // a stalled response holds
   `IRFPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // the end of a frame leaves the sender idle
   `IRFPS_ASSERT_NOW(a_done_idle, clock, reset, rsp_tvalid && rsp_tdata[2], !rsp_tdata[1])

   // line is low whenever nothing is being sent
   `IRFPS_ASSERT_NOW(a_idle_low, clock, reset, rsp_tvalid && !rsp_tdata[1], !rsp_tdata[0])

   // a taken command never coincides with a frame end
   `IRFPS_ASSERT_NOW(a_acc_not_done, clock, reset, rsp_tvalid && rsp_tdata[3], !rsp_tdata[2])

endmodule

bind ir_frame_pulse_distance_sender_top irfps_checker u_irfps_checker (.*);

[dv/tb_ir_frame_pulse_distance_sender_top.sv]
// ----------------------------------------------------------------------------
// tb_ir_frame_pulse_distance_sender_top
// self-checking bench for the ir frame sender: request words are streamed in
// with random gaps, and every response word is compared with the prediction of
// a small scoreboard that keeps its own copy of the frame store, sequencer
// state and timing registers
// ----------------------------------------------------------------------------
module tb_ir_frame_pulse_distance_sender_top;
   timeunit 1ns;
   timeprecision 1ps;

   import irfps_pkg::*;

   localparam int FRAME_LEN = 18;
   // the fourth kind code has no meaning in the block
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // settle time after the last expected word
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT = 4000;

   // -------------------------------------------------------------------------
   // scoreboard: predicts the response word for each accepted request word
   // -------------------------------------------------------------------------
   class frame_sender_scoreboard;
      cfg_type     regs;
      logic [7:0]  store [FRAME_LEN];
      phase_type   ph;
      logic [4:0]  byte_pos;
      logic [2:0]  bit_pos;
      logic [3:0]  pass_cnt;
      logic [9:0]  period_cnt;
      logic [4:0]  carrier_cnt;
      logic [15:0] space_cnt;
      logic        level;
      result_type  expected_words [$];
      int unsigned errors;

      function new();
         regs = '{header_mark_periods: 10'd131, header_space_us: 16'd1750,
                  bit_mark_periods: 10'd18, one_space_us: 16'd1300,
                  zero_space_us: 16'd420, trailer_mark_periods: 10'd17,
                  trailer_space_us: 16'd17100, repeat_count: 4'd2};
         foreach (store[k]) store[k] = 8'h00;
         ph          = PH_IDLE;
         byte_pos    = '0;
         bit_pos     = '0;
         pass_cnt    = '0;
         period_cnt  = '0;
         carrier_cnt = '0;
         space_cnt   = '0;
         level       = 1'b0;
         errors      = 0;
      endfunction

      function void write_reg(logic [3:0] idx, logic [15:0] data);
         case (idx)
            CSR_HDR_MARK:   regs.header_mark_periods  = data[9:0];
            CSR_HDR_SPACE:  regs.header_space_us      = data;
            CSR_BIT_MARK:   regs.bit_mark_periods     = data[9:0];
            CSR_ONE_SPACE:  regs.one_space_us         = data;
            CSR_ZERO_SPACE: regs.zero_space_us        = data;
            CSR_TRL_MARK:   regs.trailer_mark_periods = data[9:0];
            CSR_TRL_SPACE:  regs.trailer_space_us     = data;
            CSR_REPEAT:     regs.repeat_count         = data[3:0];
            default: ;
         endcase
      endfunction

      // a zero in a count register behaves as one
      function int unsigned floor_one(int unsigned v);
         return (v == 0) ? 1 : v;
      endfunction

      function int unsigned mark_len();
         if (ph == PH_HDR_MARK) return floor_one(regs.header_mark_periods);
         if (ph == PH_BIT_MARK) return floor_one(regs.bit_mark_periods);
         return floor_one(regs.trailer_mark_periods);
      endfunction

      function int unsigned space_len();
         logic bit_now;
         bit_now = (byte_pos < FRAME_LEN) ? store[byte_pos][bit_pos] : 1'b0;
         if (ph == PH_HDR_SPACE) return floor_one(regs.header_space_us);
         if (ph == PH_BIT_SPACE)
            return floor_one(bit_now ? regs.one_space_us : regs.zero_space_us);
         return floor_one(regs.trailer_space_us);
      endfunction

      // one microsecond of line activity; returns the end-of-frame pulse
      function logic advance_tick();
         logic done;
         done = 1'b0;
         case (ph)
            PH_HDR_MARK, PH_BIT_MARK, PH_TRL_MARK: begin
               level = (carrier_cnt < CARRIER_HIGH);
               carrier_cnt++;
               if (carrier_cnt >= CARRIER_PERIOD) begin
                  carrier_cnt = '0;
                  if (period_cnt + 1 >= mark_len()) begin
                     period_cnt = '0;
                     space_cnt  = '0;
                     if (ph == PH_HDR_MARK) ph = PH_HDR_SPACE;
                     else if (ph == PH_BIT_MARK) ph = PH_BIT_SPACE;
                     else ph = PH_TRL_SPACE;
                  end else begin
                     period_cnt++;
                  end
               end
            end
            PH_HDR_SPACE, PH_BIT_SPACE, PH_TRL_SPACE: begin
               level = 1'b0;
               if (space_cnt + 1 >= space_len()) begin
                  space_cnt = '0;
                  if (ph == PH_HDR_SPACE) begin
                     ph = PH_BIT_MARK;
                  end else if (ph == PH_BIT_SPACE) begin
                     if (bit_pos == 3'd7) begin
                        bit_pos = '0;
                        byte_pos++;
                        if (byte_pos >= FRAME_LEN) begin
                           byte_pos = '0;
                           ph = PH_TRL_MARK;
                        end else begin
                           ph = PH_BIT_MARK;
                        end
                     end else begin
                        bit_pos++;
                        ph = PH_BIT_MARK;
                     end
                  end else if (pass_cnt + 1 >= floor_one(regs.repeat_count)) begin
                     pass_cnt = '0;
                     ph = PH_IDLE;
                     done = 1'b1;
                  end else begin
                     pass_cnt++;
                     ph = PH_HDR_MARK;
                  end
               end else begin
                  space_cnt++;
               end
            end
            default: begin
               ph = PH_IDLE;
               level = 1'b0;
            end
         endcase
         return done;
      endfunction

      function void note_item(logic [1:0] op, logic [4:0] idx, logic [7:0] val);
         result_type r;
         logic       busy_now;
         busy_now = (ph != PH_IDLE);
         r = '0;
         case (op)
            OP_LOAD: begin
               if (!busy_now) begin
                  r.accepted = 1'b1;
                  if (idx < FRAME_LEN) store[idx] = val;
               end
            end
            OP_START: begin
               if (!busy_now) begin
                  r.accepted = 1'b1;
                  for (int k = 0; k < CHECK_LEN; k++)
                     store[CHECK_DST + k] = BYTE_MASK ^ store[CHECK_SRC + k];
                  ph          = PH_HDR_MARK;
                  byte_pos    = '0;
                  bit_pos     = '0;
                  pass_cnt    = '0;
                  period_cnt  = '0;
                  carrier_cnt = '0;
                  space_cnt   = '0;
               end
            end
            OP_TICK: r.frame_done = advance_tick();
            default: ;
         endcase
         r.ir_level = level;
         r.busy_res = (ph != PH_IDLE);
         expected_words.push_back(r);
      endfunction

      function void report(string field, logic exp_v, logic act_v);
         errors++;
         $display("%0t: %s mismatch, expected %b actual %b", $time, field, exp_v, act_v);
      endfunction

      function void check_result(logic [7:0] word);
         result_type got;
         result_type want;
         got = word[3:0];
         if (expected_words.size() == 0) begin
            errors++;
            $display("%0t: response word with nothing expected, expected none actual %h",
                     $time, word);
            return;
         end
         want = expected_words.pop_front();
         if (got.ir_level !== want.ir_level) report("ir_level", want.ir_level, got.ir_level);
         if (got.busy_res !== want.busy_res) report("busy_res", want.busy_res, got.busy_res);
         if (got.frame_done !== want.frame_done)
            report("frame_done", want.frame_done, got.frame_done);
         if (got.accepted !== want.accepted) report("accepted", want.accepted, got.accepted);
      endfunction

      function bit busy();
         return ph != PH_IDLE;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // signals and block instance
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // byte_index[4:0], byte_value[12:5], zero pad
   logic [1:0]  req_tuser = OP_LOAD; // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // ir_level[0], busy_res[1], frame_done[2],
                                   // accepted[3], zero pad
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // idling switches, changed between phases of the run
   bit req_gaps = 1'b1;
   bit rsp_stalls = 1'b1;

   frame_sender_scoreboard sb;

   ir_frame_pulse_distance_sender_top #(
      .FRAME_BYTES (FRAME_LEN)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // driving tasks
   // -------------------------------------------------------------------------

   // one request word; valid stays high afterwards unless a gap or drain follows
   task automatic send_item(input logic [1:0] op, input logic [4:0] idx,
                            input logic [7:0] val);
      if (req_gaps && $urandom_range(0, 15) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, val, idx};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_item(op, idx, val);
   endtask

   // payload bits of a tick are don't-care, so they carry random junk
   task automatic tick_once();
      send_item(OP_TICK, 5'($urandom), 8'($urandom));
   endtask

   // stop sending and let every expected word come back
   task automatic drain();
      int unsigned waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // writes all eight registers back to back; only called while drained
   task automatic program_timing(input cfg_type c);
      logic [3:0]  idxs [8];
      logic [15:0] vals [8];
      idxs = '{CSR_HDR_MARK, CSR_HDR_SPACE, CSR_BIT_MARK, CSR_ONE_SPACE,
               CSR_ZERO_SPACE, CSR_TRL_MARK, CSR_TRL_SPACE, CSR_REPEAT};
      vals = '{16'(c.header_mark_periods), c.header_space_us,
               16'(c.bit_mark_periods), c.one_space_us, c.zero_space_us,
               16'(c.trailer_mark_periods), c.trailer_space_us,
               16'(c.repeat_count)};
      for (int k = 0; k < 8; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idxs[k];
         csr_data  <= vals[k];
         do @(posedge clock); while (csr_ready !== 1'b1);
         sb.write_reg(idxs[k], vals[k]);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic cfg_type timing_set(int unsigned hm, int unsigned hs,
                                          int unsigned bm, int unsigned os,
                                          int unsigned zs, int unsigned tm,
                                          int unsigned ts, int unsigned rep);
      cfg_type c;
      c.header_mark_periods  = 10'(hm);
      c.header_space_us      = 16'(hs);
      c.bit_mark_periods     = 10'(bm);
      c.one_space_us         = 16'(os);
      c.zero_space_us        = 16'(zs);
      c.trailer_mark_periods = 10'(tm);
      c.trailer_space_us     = 16'(ts);
      c.repeat_count         = 4'(rep);
      return c;
   endfunction

   // ticks on the running frame; busy loads and starts and unused codes are
   // sprinkled in as noise
   task automatic run_ticks(input int n_ticks, input int noise_rate);
      for (int k = 0; k < n_ticks; k++) begin
         if ($urandom_range(0, 63) < noise_rate) begin
            case ($urandom_range(0, 2))
               0: send_item(OP_LOAD, 5'($urandom), 8'($urandom));
               1: send_item(OP_START, 5'($urandom), 8'($urandom));
               default: send_item(OP_UNUSED, 5'($urandom), 8'($urandom));
            endcase
         end else begin
            tick_once();
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // response side: check each word taken, stall in random bursts
   // -------------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
            sb.check_result(rsp_tdata);
         if (stall_left > 0)
            stall_left--;
         else if (rsp_stalls && $urandom_range(0, 15) == 0)
            stall_left = $urandom_range(1, 12);
         rsp_tready <= (stall_left == 0);
      end
   end

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle behaviour at reset timing: unused code and a tick do nothing
      send_item(OP_UNUSED, 5'h1f, 8'hff);
      tick_once();
      // store edges, out-of-range indexes still count as taken
      send_item(OP_LOAD, 5'd0, 8'h00);
      send_item(OP_LOAD, 5'd17, 8'hff);
      send_item(OP_LOAD, 5'd18, 8'haa);
      send_item(OP_LOAD, 5'd31, 8'h55);
      // check-byte sources, and a value in byte 11 the start must overwrite
      send_item(OP_LOAD, 5'd5, 8'hff);
      send_item(OP_LOAD, 5'd6, 8'h00);
      send_item(OP_LOAD, 5'd7, 8'ha5);
      send_item(OP_LOAD, 5'd11, 8'h3c);
      send_item(OP_UNUSED, 5'd0, 8'h00);
      tick_once();
      // random content in the leading bytes so both space lengths show up
      for (int k = 0; k < 5; k++) send_item(OP_LOAD, 5'(k), 8'($urandom));
      drain();

      // zero everywhere: one-period marks and one-tick spaces
      program_timing('0);
      send_item(OP_START, 5'd0, 8'h00);
      // busy load and busy start are both refused
      send_item(OP_LOAD, 5'd1, 8'h81);
      send_item(OP_START, 5'd0, 8'h00);
      send_item(OP_UNUSED, 5'd3, 8'h7e);
      run_ticks(350, 2);
      drain();

      // every register at its top value in mid-frame; the stage then in
      // progress stretches until the registers shrink again below
      program_timing(timing_set(1023, 65535, 1023, 65535, 65535, 1023, 65535, 15));
      run_ticks(250, 3);
      drain();

      // random short timings, idling switched per stretch; a shrunk register
      // ends the running stage at the next boundary
      repeat (4) begin
         req_gaps = $urandom_range(0, 3) != 0;
         rsp_stalls = $urandom_range(0, 3) != 0;
         program_timing(timing_set($urandom_range(0, 3), $urandom_range(0, 8),
                                   $urandom_range(0, 3), $urandom_range(0, 8),
                                   $urandom_range(0, 8), $urandom_range(0, 3),
                                   $urandom_range(0, 8), $urandom_range(0, 2)));
         run_ticks(200, 4);
         drain();
      end

      // closing stretch at full rate on both sides
      req_gaps = 1'b0;
      rsp_stalls = 1'b0;
      program_timing(timing_set($urandom_range(1, 2), $urandom_range(0, 4), 1,
                                $urandom_range(0, 4), $urandom_range(0, 4), 1,
                                $urandom_range(0, 4), 1));
      run_ticks(300, 4);
      drain();

      if (sb.pending() != 0) begin
         $display("%0t: %0d expected response words never arrived, expected 0 actual %0d",
                  $time, sb.pending(), sb.pending());
         sb.errors += sb.pending();
      end
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/irfps_pkg.sv
rtl/core/irfps_cfg_regs.sv
rtl/core/irfps_frame_store.sv
rtl/core/irfps_sequencer.sv
rtl/core/ir_frame_pulse_distance_sender_top.sv
rtl/core/irfps_checker.sv
dv/tb_ir_frame_pulse_distance_sender_top.sv
